FILE: rtl/rhc_pkg.sv
package rhc_pkg;

  // Default fraction width of the fixed-point HSL fields
  localparam int FracBitsDef = 16;

  // Conversion direction, as held in the direction register
  typedef enum logic {
    DirRgbToHsl = 1'b0,
    DirHslToRgb = 1'b1
  } dir_e;

endpackage

FILE: rtl/rhc_in_if.sv
interface rhc_in_if #(
  parameter int FracBits = rhc_pkg::FracBitsDef
) ();

  logic                valid;
  logic                ready;
  logic [7:0]          in_red;
  logic [7:0]          in_green;
  logic [7:0]          in_blue;
  logic [FracBits:0]   in_hue;
  logic [FracBits:0]   in_saturation;
  logic [FracBits:0]   in_lightness;

  modport source (
    output valid, in_red, in_green, in_blue, in_hue, in_saturation, in_lightness,
    input  ready
  );

  modport sink (
    input  valid, in_red, in_green, in_blue, in_hue, in_saturation, in_lightness,
    output ready
  );

endinterface

FILE: rtl/rhc_out_if.sv
interface rhc_out_if #(
  parameter int FracBits = rhc_pkg::FracBitsDef
) ();

  logic                valid;
  logic                ready;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic [FracBits:0]   out_hue;
  logic [FracBits:0]   out_saturation;
  logic [FracBits:0]   out_lightness;

  modport source (
    output valid, out_red, out_green, out_blue, out_hue, out_saturation, out_lightness,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_hue, out_saturation, out_lightness,
    output ready
  );

endinterface

FILE: rtl/rgb_hsl_color_converter_core.sv
// An input word passes stages 0 to 3, then the divider stages, then post stages 1 to 3 to the output word.
// Throughput: one word per cycle while the output is ready; every stage advances on its own, so bubbles close up.
// Depth is set by the restoring dividers, which retire one quotient bit per stage.
// Reset (async, active low) clears all stage valid bits and sets the direction
// register to RGB-to-HSL; data registers are not reset.
module rgb_hsl_color_converter_core #(
  parameter int FracBits = rhc_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        dir_we_i,
  input  logic [0:0]  dir_wdata_i,
  rhc_in_if.sink      in_i,
  rhc_out_if.source   out_o
);
  import rhc_pkg::*;

  localparam int W      = FracBits + 1;
  localparam int SW     = FracBits + 3;
  localparam int NumDiv = FracBits + 1;
  localparam int DivIdx = 4;
  localparam int P1Idx  = DivIdx + NumDiv;
  localparam int P2Idx  = P1Idx + 1;
  localparam int P3Idx  = P2Idx + 1;
  localparam int NumStg = P3Idx + 1;
  localparam int K3     = FracBits + 2;

  localparam logic [W-1:0] One      = W'(1) << FracBits;
  localparam logic [W-1:0] Half     = One >> 1;
  localparam logic [W-1:0] Third    = W'((longint'(1) << FracBits) / 3);
  localparam logic [W-1:0] TwoThird = W'((longint'(2) << FracBits) / 3);
  localparam logic [W-1:0] Q0       = W'((longint'(1) << FracBits) / 255);
  localparam logic [7:0]   R0       = 8'((longint'(1) << FracBits) % 255);
  localparam logic [W-1:0] M3       = W'(((longint'(1) << K3) + 2) / 3);

  typedef struct packed {
    dir_e                dir;
    logic                bypass;
    logic                rmax;
    logic                gmax;
    logic [W-1:0]        l;
    logic [W-1:0]        v;
    logic [W-1:0]        m;
    logic [2:0]          sext;
    logic [FracBits-1:0] fract;
  } side_t;

  // Channel to fraction: c * ONE / 255, split into c * (ONE / 255) plus a small remainder
  function automatic logic [W-1:0] chan_frac(input logic [7:0] c);
    logic [W+7:0] hi;
    logic [15:0]  z;
    logic [15:0]  zq;
    hi = {{W{1'b0}}, c} * {8'h00, Q0};
    z  = {8'h00, c} * {8'h00, R0};
    zq = (z + (z >> 8) + 16'd1) >> 8;
    return hi[W-1:0] + {{(W-8){1'b0}}, zq[7:0]};
  endfunction

  function automatic logic [W-1:0] clamp_u(input logic [W-1:0] x);
    return (x > One) ? One : x;
  endfunction

  function automatic logic [W-1:0] clamp_s(input logic signed [SW-1:0] x);
    logic [W-1:0] y;
    if (x < 0) begin
      y = '0;
    end else if (x > $signed({2'b00, One})) begin
      y = One;
    end else begin
      y = x[W-1:0];
    end
    return y;
  endfunction

  // Floor of d / 6 as floor((d >> 1) / 3) by reciprocal multiply
  function automatic logic [W-1:0] div6(input logic [W-1:0] d);
    logic [2*W:0] p;
    p = {{(W+1){1'b0}}, d >> 1} * {{(W+1){1'b0}}, M3};
    return p[K3 +: W];
  endfunction

  // Fraction to 8-bit channel: (x * 255) >> FracBits
  function automatic logic [7:0] to_chan(input logic [W-1:0] x);
    logic [W+7:0] p;
    p = {x, 8'h00} - {8'h00, x};
    return p[FracBits +: 8];
  endfunction

  // Direction register
  dir_e dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirRgbToHsl;
    end else if (dir_we_i) begin
      dir_q <= dir_e'(dir_wdata_i[0]);
    end
  end

  // Valid bits and per-stage advance
  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   en;

  always_comb begin
    en[NumStg] = out_o.ready;
    for (int k = NumStg - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // Stage 0: channel fractions, clamped HSL inputs, l * s
  dir_e           s0_dir_q;
  logic [W-1:0]   s0_r_q, s0_g_q, s0_b_q, s0_h_q, s0_s_q, s0_l_q;
  logic [2*W-1:0] s0_p_q;
  logic [W-1:0]   in_h, in_s, in_l;

  assign in_h = clamp_u(in_i.in_hue);
  assign in_s = clamp_u(in_i.in_saturation);
  assign in_l = clamp_u(in_i.in_lightness);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_dir_q <= dir_q;
      s0_r_q   <= chan_frac(in_i.in_red);
      s0_g_q   <= chan_frac(in_i.in_green);
      s0_b_q   <= chan_frac(in_i.in_blue);
      s0_h_q   <= in_h;
      s0_s_q   <= in_s;
      s0_l_q   <= in_l;
      s0_p_q   <= {{W{1'b0}}, in_l} * {{W{1'b0}}, in_s};
    end
  end

  // Stage 1: max, min, delta, per-channel distance; v for the reverse path
  dir_e         s1_dir_q;
  logic [W-1:0] s1_delta_q, s1_dr_q, s1_dg_q, s1_db_q, s1_v_q, s1_h_q, s1_l_q;
  logic [W:0]   s1_sum_q;
  logic         s1_rmax_q, s1_gmax_q;
  logic [W-1:0] mx, mn, ls;
  logic [W:0]   vw;

  always_comb begin
    mx = s0_r_q;
    mn = s0_r_q;
    if (s0_g_q > mx) mx = s0_g_q;
    if (s0_b_q > mx) mx = s0_b_q;
    if (s0_g_q < mn) mn = s0_g_q;
    if (s0_b_q < mn) mn = s0_b_q;
    ls = s0_p_q[FracBits +: W];
    if (s0_l_q <= Half) begin
      vw = {1'b0, s0_l_q} + {1'b0, ls};
    end else begin
      vw = {1'b0, s0_l_q} + {1'b0, s0_s_q} - {1'b0, ls};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_dir_q   <= s0_dir_q;
      s1_delta_q <= mx - mn;
      s1_sum_q   <= {1'b0, mx} + {1'b0, mn};
      s1_rmax_q  <= (s0_r_q == mx);
      s1_gmax_q  <= (s0_g_q == mx);
      s1_dr_q    <= mx - s0_r_q;
      s1_dg_q    <= mx - s0_g_q;
      s1_db_q    <= mx - s0_b_q;
      s1_v_q     <= vw[W-1:0];
      s1_h_q     <= s0_h_q;
      s1_l_q     <= s0_l_q;
    end
  end

  // Stage 2: distances over six, saturation divisor; m, sextant and fraction
  dir_e                s2_dir_q;
  logic [W-1:0]        s2_delta_q, s2_den_q, s2_lf_q, s2_q6r_q, s2_q6g_q, s2_q6b_q;
  logic [W-1:0]        s2_v_q, s2_m_q, s2_num_q, s2_l_q;
  logic                s2_rmax_q, s2_gmax_q;
  logic [2:0]          s2_sext_q;
  logic [FracBits-1:0] s2_fract_q;
  logic [W-1:0]        lf, den, m_c;
  logic [W:0]          den_w, l2;
  logic [W+1:0]        h6;

  always_comb begin
    lf    = s1_sum_q[W:1];
    den_w = {One, 1'b0} - s1_sum_q;
    den   = (lf < Half) ? s1_sum_q[W-1:0] : den_w[W-1:0];
    l2    = {s1_l_q, 1'b0};
    m_c   = (l2 < {1'b0, s1_v_q}) ? '0 : W'(l2 - {1'b0, s1_v_q});
    h6    = {s1_h_q, 2'b00} + {1'b0, s1_h_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_dir_q   <= s1_dir_q;
      s2_delta_q <= s1_delta_q;
      s2_den_q   <= den;
      s2_lf_q    <= lf;
      s2_rmax_q  <= s1_rmax_q;
      s2_gmax_q  <= s1_gmax_q;
      s2_q6r_q   <= div6(s1_dr_q);
      s2_q6g_q   <= div6(s1_dg_q);
      s2_q6b_q   <= div6(s1_db_q);
      s2_v_q     <= s1_v_q;
      s2_m_q     <= m_c;
      s2_num_q   <= s1_v_q - m_c;
      s2_sext_q  <= h6[FracBits +: 3];
      s2_fract_q <= h6[FracBits-1:0];
      s2_l_q     <= s1_l_q;
    end
  end

  // Stage 3: divider operands for the four lanes
  side_t        s3_side_q;
  logic [W-1:0] s3_num_q [4];
  logic [W-1:0] s3_den_q [4];
  side_t        side3;
  logic [W-1:0] num3 [4];
  logic [W-1:0] den3 [4];

  always_comb begin
    side3.dir   = s2_dir_q;
    side3.rmax  = s2_rmax_q;
    side3.gmax  = s2_gmax_q;
    side3.v     = s2_v_q;
    side3.m     = s2_m_q;
    side3.sext  = s2_sext_q;
    side3.fract = s2_fract_q;
    num3[1] = s2_q6r_q + (s2_delta_q >> 1);
    num3[2] = s2_q6g_q + (s2_delta_q >> 1);
    num3[3] = s2_q6b_q + (s2_delta_q >> 1);
    den3[1] = s2_delta_q;
    den3[2] = s2_delta_q;
    den3[3] = s2_delta_q;
    if (s2_dir_q == DirRgbToHsl) begin
      side3.bypass = (s2_delta_q == '0);
      side3.l      = s2_lf_q;
      num3[0]      = s2_delta_q;
      den3[0]      = s2_den_q;
    end else begin
      side3.bypass = (s2_v_q == '0);
      side3.l      = s2_l_q;
      num3[0]      = s2_num_q;
      den3[0]      = s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_side_q <= side3;
      for (int k = 0; k < 4; k++) begin
        s3_num_q[k] <= num3[k];
        s3_den_q[k] <= den3[k];
      end
    end
  end

  // Restoring dividers: one quotient bit per stage, four lanes side by side
  logic [W:0]   dv_rem_q  [NumDiv][4];
  logic [W-1:0] dv_den_q  [NumDiv][4];
  logic [W-1:0] dv_quo_q  [NumDiv][4];
  side_t        dv_side_q [NumDiv];

  for (genvar j = 0; j < NumDiv; j++) begin : g_div
    logic [W:0]   trial  [4];
    logic [W-1:0] den_in [4];
    logic [W-1:0] quo_in [4];
    side_t        side_in;
    logic [W:0]   rem_d  [4];
    logic [W-1:0] quo_d  [4];
    logic [3:0]   qbit;

    if (j == 0) begin : g_first
      always_comb begin
        side_in = s3_side_q;
        for (int k = 0; k < 4; k++) begin
          trial[k]  = {1'b0, s3_num_q[k]};
          den_in[k] = s3_den_q[k];
          quo_in[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        side_in = dv_side_q[j-1];
        for (int k = 0; k < 4; k++) begin
          trial[k]  = dv_rem_q[j-1][k] << 1;
          den_in[k] = dv_den_q[j-1][k];
          quo_in[k] = dv_quo_q[j-1][k];
        end
      end
    end

    // Subtract where the divisor fits and shift the bit into the quotient
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        qbit[k]  = (trial[k] >= {1'b0, den_in[k]});
        rem_d[k] = qbit[k] ? (trial[k] - {1'b0, den_in[k]}) : trial[k];
        quo_d[k] = {quo_in[k][W-2:0], qbit[k]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[DivIdx + j]) begin
        dv_side_q[j] <= side_in;
        for (int k = 0; k < 4; k++) begin
          dv_rem_q[j][k] <= rem_d[k];
          dv_den_q[j][k] <= den_in[k];
          dv_quo_q[j][k] <= quo_d[k];
        end
      end
    end
  end

  // Post stage 1: hue assembly and saturation; v * sv for the reverse path
  side_t          p1_side_q;
  logic [W-1:0]   p1_h_q, p1_s_q, p1_t_q;
  side_t          sd;
  logic [W-1:0]   q0, q1, q2, q3;
  logic signed [SW-1:0] hr, hg, hb, hw;
  logic [2*W-1:0] vt;

  always_comb begin
    sd = dv_side_q[NumDiv-1];
    q0 = dv_quo_q[NumDiv-1][0];
    q1 = dv_quo_q[NumDiv-1][1];
    q2 = dv_quo_q[NumDiv-1][2];
    q3 = dv_quo_q[NumDiv-1][3];
    hr = $signed({2'b00, q1});
    hg = $signed({2'b00, q2});
    hb = $signed({2'b00, q3});
    if (sd.rmax) begin
      hw = hb - hg;
    end else if (sd.gmax) begin
      hw = $signed({2'b00, Third}) + hr - hb;
    end else begin
      hw = $signed({2'b00, TwoThird}) + hg - hr;
    end
    if (hw < 0) hw = hw + $signed({2'b00, One});
    if (hw > $signed({2'b00, One})) hw = hw - $signed({2'b00, One});
    vt = {{W{1'b0}}, sd.v} * {{W{1'b0}}, q0};
  end

  always_ff @(posedge clk_i) begin
    if (en[P1Idx]) begin
      p1_side_q <= sd;
      p1_h_q    <= sd.bypass ? '0 : clamp_s(hw);
      p1_s_q    <= sd.bypass ? '0 : clamp_u(q0);
      p1_t_q    <= vt[FracBits +: W];
    end
  end

  // Post stage 2: scale by the sextant fraction
  side_t              p2_side_q;
  logic [W-1:0]       p2_h_q, p2_s_q, p2_vsf_q;
  logic [W+FracBits-1:0] tf;

  assign tf = {{FracBits{1'b0}}, p1_t_q} * {{W{1'b0}}, p1_side_q.fract};

  always_ff @(posedge clk_i) begin
    if (en[P2Idx]) begin
      p2_side_q <= p1_side_q;
      p2_h_q    <= p1_h_q;
      p2_s_q    <= p1_s_q;
      p2_vsf_q  <= tf[FracBits +: W];
    end
  end

  // Post stage 3: for HSL-to-RGB pick channels by sextant and scale to 8 bits, else pass HSL; drive the output word
  dir_e         p3_dir_q;
  logic [7:0]   p3_red_q, p3_green_q, p3_blue_q;
  logic [W-1:0] p3_hue_q, p3_sat_q, p3_light_q;
  logic signed [SW-1:0] cv, cm, cl, mid1, mid2, cr, cg, cb;

  always_comb begin
    cv   = $signed({2'b00, p2_side_q.v});
    cm   = $signed({2'b00, p2_side_q.m});
    cl   = $signed({2'b00, p2_side_q.l});
    mid1 = cm + $signed({2'b00, p2_vsf_q});
    mid2 = cv - $signed({2'b00, p2_vsf_q});
    cr   = cl;
    cg   = cl;
    cb   = cl;
    if (!p2_side_q.bypass) begin
      unique case (p2_side_q.sext)
        3'd0:    begin cr = cv;   cg = mid1; cb = cm;   end
        3'd1:    begin cr = mid2; cg = cv;   cb = cm;   end
        3'd2:    begin cr = cm;   cg = cv;   cb = mid1; end
        3'd3:    begin cr = cm;   cg = mid2; cb = cv;   end
        3'd4:    begin cr = mid1; cg = cm;   cb = cv;   end
        3'd5:    begin cr = cv;   cg = cm;   cb = mid2; end
        default: begin cr = cl;   cg = cl;   cb = cl;   end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[P3Idx]) begin
      p3_dir_q <= p2_side_q.dir;
      if (p2_side_q.dir == DirRgbToHsl) begin
        p3_red_q   <= '0;
        p3_green_q <= '0;
        p3_blue_q  <= '0;
        p3_hue_q   <= p2_h_q;
        p3_sat_q   <= p2_s_q;
        p3_light_q <= clamp_u(p2_side_q.l);
      end else begin
        p3_red_q   <= to_chan(clamp_s(cr));
        p3_green_q <= to_chan(clamp_s(cg));
        p3_blue_q  <= to_chan(clamp_s(cb));
        p3_hue_q   <= '0;
        p3_sat_q   <= '0;
        p3_light_q <= '0;
      end
    end
  end

  assign out_o.valid          = vld_q[P3Idx];
  assign out_o.out_red        = p3_red_q;
  assign out_o.out_green      = p3_green_q;
  assign out_o.out_blue       = p3_blue_q;
  assign out_o.out_hue        = p3_hue_q;
  assign out_o.out_saturation = p3_sat_q;
  assign out_o.out_lightness  = p3_light_q;

`ifndef SYNTH
  a_fwd_rgb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && p3_dir_q == DirRgbToHsl) |->
      (out_o.out_red == 8'd0 && out_o.out_green == 8'd0 && out_o.out_blue == 8'd0))
    else $error("RGB fields not zero on an HSL result");

  a_rev_hsl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && p3_dir_q == DirHslToRgb) |->
      (out_o.out_hue == '0 && out_o.out_saturation == '0 && out_o.out_lightness == '0))
    else $error("HSL fields not zero on an RGB result");

  a_hsl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.out_hue <= One && out_o.out_saturation <= One && out_o.out_lightness <= One))
    else $error("HSL result above one");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted word not held in first stage");
`endif

endmodule
